@@ rtl/gdd_pkg.sv @@
// ----------------------------------------------------------------------------
// gdd_pkg: shared types and constants for the Gregorian day difference unit
// Transaction payloads, lane result and stage enables, and the calendar tables.
// ----------------------------------------------------------------------------
package gdd_pkg;

	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int HOUR_W  = 5;
	localparam int MIN_W   = 6;
	localparam int SEC_W   = 6;
	localparam int DIFF_W  = 22;
	localparam int NUM_W   = 24;  // signed day number, year zero gives a negative base
	localparam int DBM_W   = 9;   // days before month, up to 334

	localparam logic [HOUR_W-1:0] HOUR_MAX   = 5'd23;
	localparam logic [MIN_W-1:0]  MINUTE_MAX = 6'd59;
	localparam logic [SEC_W-1:0]  SECOND_MAX = 6'd59;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
	localparam logic [DIFF_W-1:0] DIFF_MAX   = 22'd4194303;

	// Reciprocal of 25 and of 100 in fixed point, exact over the 14-bit year range.
	localparam logic [12:0] RECIP_MUL     = 13'd5243;
	localparam int          RECIP25_SHIFT  = 17;
	localparam int          RECIP100_SHIFT = 19;
	localparam logic [8:0]  DAYS_PER_YEAR  = 9'd365;
	localparam logic signed [NUM_W-1:0] YEAR0_BASE = -24'sd365;

	typedef struct packed {
		logic [YEAR_W-1:0]  year_a;
		logic [MONTH_W-1:0] month_a;
		logic [DAY_W-1:0]   day_a;
		logic [HOUR_W-1:0]  hour_a;
		logic [MIN_W-1:0]   minute_a;
		logic [SEC_W-1:0]   second_a;
		logic [YEAR_W-1:0]  year_b;
		logic [MONTH_W-1:0] month_b;
		logic [DAY_W-1:0]   day_b;
	} req_item_t;

	typedef struct packed {
		logic              valid_res;
		logic [DIFF_W-1:0] day_difference;
	} rsp_item_t;

	typedef struct packed {
		logic                    ok;
		logic signed [NUM_W-1:0] num;
	} lane_res_t;

	typedef struct packed {
		logic s1;
		logic s2;
	} stage_en_t;

	function automatic logic [DBM_W-1:0] days_before_month(input logic [MONTH_W-1:0] m);
		logic [DBM_W-1:0] r;
		case (m)
			4'd3:    r = 9'd59;
			4'd4:    r = 9'd90;
			4'd5:    r = 9'd120;
			4'd6:    r = 9'd151;
			4'd7:    r = 9'd181;
			4'd8:    r = 9'd212;
			4'd9:    r = 9'd243;
			4'd10:   r = 9'd273;
			4'd11:   r = 9'd304;
			4'd12:   r = 9'd334;
			4'd2:    r = 9'd31;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m);
		logic [DAY_W-1:0] r;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
			4'd2:                                       r = 5'd28;
			default:                                    r = 5'd0;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/gdd_lane.sv @@
// ----------------------------------------------------------------------------
// gdd_lane: date check and day number for one date
// Two stages: reciprocal products first, then leap test, range check and sum.
// ----------------------------------------------------------------------------
module gdd_lane (
	input  logic                           clk,
	input  gdd_pkg::stage_en_t             en,
	input  logic [gdd_pkg::YEAR_W-1:0]     year,
	input  logic [gdd_pkg::MONTH_W-1:0]    month,
	input  logic [gdd_pkg::DAY_W-1:0]      day,
	output gdd_pkg::lane_res_t             res
);
	import gdd_pkg::*;

	logic [YEAR_W-1:0]              elapsed;
	logic [YEAR_W+12:0]             prod25;
	logic [YEAR_W+12:0]             prod100;

	logic [YEAR_W-1:0]              year_s1;
	logic [MONTH_W-1:0]             month_s1;
	logic [DAY_W-1:0]               day_s1;
	logic [YEAR_W-1:0]              elapsed_s1;
	logic                           yzero_s1;
	logic [22:0]                    e365_s1;
	logic [7:0]                     q100_s1;
	logic [9:0]                     q25_s1;

	logic [YEAR_W-1:0]              mul25;
	logic [4:0]                     rem25;
	logic                           leap;
	logic [DAY_W-1:0]               mlen;
	logic                           date_ok;
	logic [22:0]                    base_u;
	logic signed [NUM_W-1:0]        base_s;
	logic signed [NUM_W-1:0]        num;
	lane_res_t                      res_s2;

	assign elapsed = year - 14'd1;
	assign prod25  = year * RECIP_MUL;
	assign prod100 = elapsed * RECIP_MUL;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			year_s1    <= year;
			month_s1   <= month;
			day_s1     <= day;
			elapsed_s1 <= elapsed;
			yzero_s1   <= (year == '0);
			e365_s1    <= 23'(elapsed * DAYS_PER_YEAR);
			q100_s1    <= prod100[RECIP100_SHIFT +: 8];
			q25_s1     <= prod25[RECIP25_SHIFT +: 10];
		end
	end

	// Divisible by 100 is divisible by 4 and 25; by 400 is by 16 and 25.
	assign mul25 = {q25_s1, 4'b0000} + {1'b0, q25_s1, 3'b000} + {4'b0000, q25_s1};
	assign rem25 = 5'(year_s1 - mul25);
	assign leap  = (year_s1[1:0] == 2'b00) && ((rem25 != 5'd0) || (year_s1[3:0] == 4'b0000));

	always_comb begin
		mlen = month_length(month_s1);
		if (month_s1 == MONTH_FEB && leap) begin
			mlen = 5'd29;
		end
	end

	assign date_ok = (month_s1 != '0) && (month_s1 <= MONTH_DEC) && (day_s1 != '0)
		&& (day_s1 <= mlen);

	assign base_u = e365_s1 + {11'd0, elapsed_s1[YEAR_W-1:2]} - {15'd0, q100_s1}
		+ {17'd0, q100_s1[7:2]};
	assign base_s = yzero_s1 ? YEAR0_BASE : signed'({1'b0, base_u});
	assign num    = base_s + signed'({15'd0, days_before_month(month_s1)})
		+ signed'({23'd0, leap && (month_s1 > MONTH_FEB)})
		+ signed'({19'd0, day_s1});

	always_ff @(posedge clk) begin
		if (en.s2) begin
			res_s2.ok  <= date_ok;
			res_s2.num <= num;
		end
	end

	assign res = res_s2;

endmodule

@@ rtl/gdd_merge.sv @@
// ----------------------------------------------------------------------------
// gdd_merge: combine the two lanes into one result
// Absolute difference, saturation and invalid gating, then the output register.
// ----------------------------------------------------------------------------
module gdd_merge (
	input  logic                clk,
	input  logic                en,
	input  gdd_pkg::lane_res_t  lane_a,
	input  gdd_pkg::lane_res_t  lane_b,
	input  logic                time_ok,
	output gdd_pkg::rsp_item_t  rsp
);
	import gdd_pkg::*;

	logic signed [NUM_W-1:0] delta;
	logic [NUM_W-2:0]        mag;
	logic                    ok;
	rsp_item_t               rsp_s3;

	assign delta = lane_a.num - lane_b.num;
	assign mag   = delta[NUM_W-1] ? (NUM_W-1)'(-delta) : delta[NUM_W-2:0];
	assign ok    = lane_a.ok && lane_b.ok && time_ok;

	always_ff @(posedge clk) begin
		if (en) begin
			rsp_s3.valid_res <= ok;
			if (!ok) begin
				rsp_s3.day_difference <= '0;
			end else if (mag > {1'b0, DIFF_MAX}) begin
				rsp_s3.day_difference <= DIFF_MAX;
			end else begin
				rsp_s3.day_difference <= mag[DIFF_W-1:0];
			end
		end
	end

	assign rsp = rsp_s3;

endmodule

@@ rtl/gregorian_day_difference_unit.sv @@
// ----------------------------------------------------------------------------
// gregorian_day_difference_unit: days between two Gregorian dates
// Validates two dates and a time of day, returns the absolute day difference.
// ----------------------------------------------------------------------------
// Each request transaction carries two proleptic Gregorian dates (A and B)
// plus a time of day for A. The unit returns one response transaction per
// request: valid_res is 1 when both dates and the time are valid, and
// day_difference holds |dayno(A) - dayno(B)|, saturated to 22 bits, or 0
// when anything is invalid. Throughput is one transaction per cycle while
// rsp_ready is high, through three register stages: reciprocal products
// in each date lane, the day-number sum in each lane, and the merge stage
// that forms the difference. A stage loads when it is empty or its contents
// move on, so bubbles collapse and a new request is taken while a finished
// response waits on rsp_ready, as long as an earlier stage is empty.
module gregorian_day_difference_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  gdd_pkg::req_item_t  req_data,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output gdd_pkg::rsp_item_t  rsp_data
);
	import gdd_pkg::*;

	// Stage occupancy flags.
	logic      vld_s1;
	logic      vld_s2;
	logic      vld_s3;

	// Stage enables: a stage loads when it is empty or its contents move on.
	logic      adv_s1;
	logic      adv_s2;
	logic      adv_s3;
	stage_en_t lane_en;

	// Time-of-day check rides alongside the lanes.
	logic      time_ok;
	logic      time_ok_s1;
	logic      time_ok_s2;

	lane_res_t res_a;
	lane_res_t res_b;

	assign adv_s3    = !vld_s3 || rsp_ready;
	assign adv_s2    = !vld_s2 || adv_s3;
	assign adv_s1    = !vld_s1 || adv_s2;
	assign req_ready = adv_s1;
	assign rsp_valid = vld_s3;

	assign lane_en.s1 = adv_s1;
	assign lane_en.s2 = adv_s2;

	// Advance valid flags; hold a stage while its successor is stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (adv_s1) begin
				vld_s1 <= req_valid;
			end
			if (adv_s2) begin
				vld_s2 <= vld_s1;
			end
			if (adv_s3) begin
				vld_s3 <= vld_s2;
			end
		end
	end

	assign time_ok = (req_data.hour_a <= HOUR_MAX) && (req_data.minute_a <= MINUTE_MAX)
		&& (req_data.second_a <= SECOND_MAX);

	// Carry the time check down to the merge stage.
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			time_ok_s1 <= time_ok;
		end
		if (adv_s2) begin
			time_ok_s2 <= time_ok_s1;
		end
	end

	// Lane for date A.
	gdd_lane u_lane_a (
		.clk   (clk),
		.en    (lane_en),
		.year  (req_data.year_a),
		.month (req_data.month_a),
		.day   (req_data.day_a),
		.res   (res_a)
	);

	// Lane for date B.
	gdd_lane u_lane_b (
		.clk   (clk),
		.en    (lane_en),
		.year  (req_data.year_b),
		.month (req_data.month_b),
		.day   (req_data.day_b),
		.res   (res_b)
	);

	// Combine the lanes and drive the response register.
	gdd_merge u_merge (
		.clk     (clk),
		.en      (adv_s3),
		.lane_a  (res_a),
		.lane_b  (res_b),
		.time_ok (time_ok_s2),
		.rsp     (rsp_data)
	);

endmodule
